// ===== design/aamc_pkg.sv =====
// ----------------------------------------------------------------------------
// Accelerometer magnitude check: shared types and constants
// Field widths, verdict codes, register indexes, check limits and the
// pipeline item tag that travels with each sample.
// ----------------------------------------------------------------------------
package aamc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 32;
    localparam int SKIP_W   = 8;
    localparam int COUNT_W  = 12;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [THRESH_W-1:0]        thresh_t;
    typedef logic [SKIP_W-1:0]          skip_t;
    typedef logic [COUNT_W-1:0]         count_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_OK    = 2'd0,
        VERDICT_MAG   = 2'd1,
        VERDICT_SPIKE = 2'd2
    } verdict_t;

    localparam cfg_idx_t CFG_MAG_LOW    = 2'd0;
    localparam cfg_idx_t CFG_MAG_HIGH   = 2'd1;
    localparam cfg_idx_t CFG_SKIP_COUNT = 2'd2;

    localparam thresh_t MAG_LOW_RST    = 32'h0000_0000;
    localparam thresh_t MAG_HIGH_RST   = 32'hFFFF_FFFF;
    localparam skip_t   SKIP_COUNT_RST = 8'd4;

    localparam logic    CMD_SAMPLE = 1'b0;
    localparam logic    CMD_START  = 1'b1;

    localparam count_t  MAG_START  = 12'd10;
    localparam count_t  VERDICT_AT = 12'd2000;

    localparam sample_t XY_HI = 16'sd30;
    localparam sample_t XY_LO = -16'sd30;
    localparam sample_t Z_HI  = 16'sd300;
    localparam sample_t Z_LO  = -16'sd300;

    // Tag carried down the pipeline with each item.
    typedef struct packed {
        logic start;
        logic sample;
        logic mag_en;
        logic spike;
        logic last;
    } tag_t;

endpackage

// ===== design/aamc_sample_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying the command bit and one three-axis sample.
// ----------------------------------------------------------------------------
interface aamc_sample_if import aamc_pkg::*; ();

    logic    valid;
    logic    ready;
    logic    cmd;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;

    modport source (output valid, output cmd, output accel_x, output accel_y,
                    output accel_z, input ready);
    modport sink   (input valid, input cmd, input accel_x, input accel_y,
                    input accel_z, output ready);

endinterface

// ===== design/aamc_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the verdict of one finished run.
// ----------------------------------------------------------------------------
interface aamc_result_if import aamc_pkg::*; ();

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);

endinterface

// ===== design/aamc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and the write data.
// ----------------------------------------------------------------------------
interface aamc_cfg_if import aamc_pkg::*; ();

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    thresh_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== design/accel_average_magnitude_check_unit.sv =====
// ----------------------------------------------------------------------------
// Accelerometer average magnitude check
// Checks a three-axis sample stream against a moving-average magnitude
// window and single-axis spike limits, and reports one verdict per run.
// ----------------------------------------------------------------------------
// Usage:
// A start item (cmd = 1) clears the run and arms the check; the next
// skip_count sample items are dropped, then every sample is checked. The
// 2002nd checked sample closes the run: one verdict item leaves on the
// result channel and the block disarms until the next start.
// Samples update the ring and running sums in the cycle they are accepted;
// the divide-by-window multiply, the squares, the magnitude sum and the
// window compare follow in four registered stages; the last one loads the
// verdict register. One item is accepted every cycle. The only stall comes
// when a verdict reaches the last stage while the previous verdict is still
// unread; the whole pipeline then holds and sample.ready drops until
// result.ready is seen. cfg.ready is always high. Reset disarms the block,
// clears the run state and loads the register defaults; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module accel_average_magnitude_check_unit import aamc_pkg::*; #(
    parameter int WINDOW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    aamc_sample_if.sink   sample,
    aamc_result_if.source result,
    aamc_cfg_if.sink      cfg
);

    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SUM_W   = SAMPLE_W + 1 + LOG_W;
    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT   = MAG_W + LOG_W;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int AVG_W   = SAMPLE_W;
    localparam int SQ_W    = 2 * AVG_W;
    localparam int DEPTH   = WINDOW + 1;
    localparam int POS_W   = $clog2(DEPTH);

    // Rounded-up reciprocal: exact floor division for every magnitude below 2^MAG_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW);

    typedef logic signed [SUM_W-1:0] sum_t;

    // Configuration registers
    thresh_t mag_low_reg;
    thresh_t mag_high_reg;
    skip_t   skip_count_reg;

    // Run state
    sample_t          ring_x_reg [DEPTH];
    sample_t          ring_y_reg [DEPTH];
    sample_t          ring_z_reg [DEPTH];
    sample_t          ring_x_next [DEPTH];
    sample_t          ring_y_next [DEPTH];
    sample_t          ring_z_next [DEPTH];
    logic [POS_W-1:0] pos_reg, pos_next, pos_succ;
    sum_t             sum_x_reg, sum_y_reg, sum_z_reg;
    sum_t             sum_x_next, sum_y_next, sum_z_next;
    sum_t             upd_x, upd_y, upd_z;
    count_t           checked_count_reg, checked_count_next;
    logic             enabled_reg, enabled_next;
    skip_t            skip_left_reg, skip_left_next;
    verdict_t         fail_code_reg, fail_code_next, fail_new;

    // Pipeline
    tag_t              s1_tag_reg, s1_tag_next, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    sum_t              s1_sum_x_reg, s1_sum_y_reg, s1_sum_z_reg;
    logic [PROD_W-1:0] s2_prod_x_reg, s2_prod_y_reg, s2_prod_z_reg;
    logic [SQ_W-1:0]   s3_sq_x_reg, s3_sq_y_reg, s3_sq_z_reg;
    thresh_t           s4_mag_reg;
    logic [MAG_W-1:0]  abs_x, abs_y, abs_z;
    logic [AVG_W-1:0]  avg_x, avg_y, avg_z;

    logic     out_valid_reg, out_valid_next;
    verdict_t verdict_reg, verdict_next;

    logic stall;
    logic advance;
    logic accept;

    assign stall   = s4_tag_reg.last && out_valid_reg && !result.ready;
    assign advance = !stall;
    assign accept  = sample.valid && sample.ready;

    assign sample.ready  = advance;
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.verdict = verdict_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_low_reg    <= MAG_LOW_RST;
            mag_high_reg   <= MAG_HIGH_RST;
            skip_count_reg <= SKIP_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_MAG_LOW:    mag_low_reg    <= cfg.data;
                CFG_MAG_HIGH:   mag_high_reg   <= cfg.data;
                CFG_SKIP_COUNT: skip_count_reg <= cfg.data[SKIP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Ring and running sums for the incoming sample
    assign pos_succ = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign upd_x = sum_x_reg + SUM_W'(sample.accel_x) - SUM_W'(ring_x_reg[pos_succ]);
    assign upd_y = sum_y_reg + SUM_W'(sample.accel_y) - SUM_W'(ring_y_reg[pos_succ]);
    assign upd_z = sum_z_reg + SUM_W'(sample.accel_z) - SUM_W'(ring_z_reg[pos_succ]);

    always_comb
    begin
        ring_x_next        = ring_x_reg;
        ring_y_next        = ring_y_reg;
        ring_z_next        = ring_z_reg;
        pos_next           = pos_reg;
        sum_x_next         = sum_x_reg;
        sum_y_next         = sum_y_reg;
        sum_z_next         = sum_z_reg;
        checked_count_next = checked_count_reg;
        enabled_next       = enabled_reg;
        skip_left_next     = skip_left_reg;
        s1_tag_next        = '0;

        if (accept)
        begin
            if (sample.cmd == CMD_START)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    ring_x_next[i] = '0;
                    ring_y_next[i] = '0;
                    ring_z_next[i] = '0;
                end
                pos_next           = '0;
                sum_x_next         = '0;
                sum_y_next         = '0;
                sum_z_next         = '0;
                checked_count_next = '0;
                skip_left_next     = skip_count_reg;
                enabled_next       = 1'b1;
                s1_tag_next.start  = 1'b1;
            end
            else if (enabled_reg)
            begin
                if (skip_left_reg != '0)
                begin
                    skip_left_next = skip_left_reg - 1'b1;
                end
                else
                begin
                    s1_tag_next.sample = 1'b1;
                    s1_tag_next.mag_en = checked_count_reg > MAG_START;
                    s1_tag_next.spike  = (sample.accel_x > XY_HI) || (sample.accel_x < XY_LO)
                                      || (sample.accel_y > XY_HI) || (sample.accel_y < XY_LO)
                                      || (sample.accel_z > Z_HI)  || (sample.accel_z < Z_LO);
                    s1_tag_next.last   = checked_count_reg > VERDICT_AT;

                    if (checked_count_reg > VERDICT_AT)
                    begin
                        // Run closes: clear as a start would, then disarm.
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            ring_x_next[i] = '0;
                            ring_y_next[i] = '0;
                            ring_z_next[i] = '0;
                        end
                        pos_next           = '0;
                        sum_x_next         = '0;
                        sum_y_next         = '0;
                        sum_z_next         = '0;
                        checked_count_next = '0;
                        skip_left_next     = skip_count_reg;
                        enabled_next       = 1'b0;
                    end
                    else
                    begin
                        ring_x_next[pos_reg] = sample.accel_x;
                        ring_y_next[pos_reg] = sample.accel_y;
                        ring_z_next[pos_reg] = sample.accel_z;
                        pos_next             = pos_succ;
                        sum_x_next           = upd_x;
                        sum_y_next           = upd_y;
                        sum_z_next           = upd_z;
                        checked_count_next   = checked_count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_x_reg[i] <= '0;
                ring_y_reg[i] <= '0;
                ring_z_reg[i] <= '0;
            end
            pos_reg           <= '0;
            sum_x_reg         <= '0;
            sum_y_reg         <= '0;
            sum_z_reg         <= '0;
            checked_count_reg <= '0;
            enabled_reg       <= 1'b0;
            skip_left_reg     <= '0;
        end
        else
        begin
            ring_x_reg        <= ring_x_next;
            ring_y_reg        <= ring_y_next;
            ring_z_reg        <= ring_z_next;
            pos_reg           <= pos_next;
            sum_x_reg         <= sum_x_next;
            sum_y_reg         <= sum_y_next;
            sum_z_reg         <= sum_z_next;
            checked_count_reg <= checked_count_next;
            enabled_reg       <= enabled_next;
            skip_left_reg     <= skip_left_next;
        end
    end

    // Magnitude datapath
    assign abs_x = MAG_W'(s1_sum_x_reg[SUM_W-1] ? -s1_sum_x_reg : s1_sum_x_reg);
    assign abs_y = MAG_W'(s1_sum_y_reg[SUM_W-1] ? -s1_sum_y_reg : s1_sum_y_reg);
    assign abs_z = MAG_W'(s1_sum_z_reg[SUM_W-1] ? -s1_sum_z_reg : s1_sum_z_reg);

    assign avg_x = s2_prod_x_reg[SHIFT +: AVG_W];
    assign avg_y = s2_prod_y_reg[SHIFT +: AVG_W];
    assign avg_z = s2_prod_z_reg[SHIFT +: AVG_W];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // The pipeline sees the updated sums even on the closing sample.
            s1_sum_x_reg  <= upd_x;
            s1_sum_y_reg  <= upd_y;
            s1_sum_z_reg  <= upd_z;
            s2_prod_x_reg <= PROD_W'(abs_x) * PROD_W'(RECIP);
            s2_prod_y_reg <= PROD_W'(abs_y) * PROD_W'(RECIP);
            s2_prod_z_reg <= PROD_W'(abs_z) * PROD_W'(RECIP);
            s3_sq_x_reg   <= SQ_W'(avg_x) * SQ_W'(avg_x);
            s3_sq_y_reg   <= SQ_W'(avg_y) * SQ_W'(avg_y);
            s3_sq_z_reg   <= SQ_W'(avg_z) * SQ_W'(avg_z);
            s4_mag_reg    <= THRESH_W'(34'(s3_sq_x_reg) + 34'(s3_sq_y_reg)
                                       + 34'(s3_sq_z_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
        end
        else if (advance)
        begin
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
        end
    end

    // Verdict tracking: the latest failure wins, the spike test last.
    always_comb
    begin
        fail_new = fail_code_reg;
        if (s4_tag_reg.start)
        begin
            fail_new = VERDICT_OK;
        end
        if (s4_tag_reg.sample)
        begin
            if (s4_tag_reg.mag_en && ((s4_mag_reg < mag_low_reg) || (s4_mag_reg > mag_high_reg)))
            begin
                fail_new = VERDICT_MAG;
            end
            if (s4_tag_reg.spike)
            begin
                fail_new = VERDICT_SPIKE;
            end
        end

        fail_code_next = fail_code_reg;
        out_valid_next = out_valid_reg && !result.ready;
        verdict_next   = verdict_reg;
        if (advance)
        begin
            fail_code_next = s4_tag_reg.last ? VERDICT_OK : fail_new;
            if (s4_tag_reg.last)
            begin
                out_valid_next = 1'b1;
                verdict_next   = fail_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_code_reg <= VERDICT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fail_code_reg <= fail_code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

`ifndef NO_ASSERTIONS
    // A verdict only appears right after a closing sample left the last stage.
    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_tag_reg.last))
        else $error("verdict raised without a closing sample");

    // Input back-pressure only while a verdict collides with an unread one.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (out_valid_reg && s4_tag_reg.last))
        else $error("sample channel stalled without a pending verdict");

    // A disarmed block holds a cleared run.
    a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !enabled_reg |-> ((checked_count_reg == '0) && (pos_reg == '0)))
        else $error("run state not cleared while disarmed");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("ring write position out of range");
`endif

endmodule

// ===== tb/sv/aamc_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Verdict checker for the accelerometer magnitude check
// Watches the sample, configuration and result channels, keeps its own copy
// of the run state and thresholds, predicts the verdict of every run and
// compares each verdict item that leaves the block with the oldest one due.
// ----------------------------------------------------------------------------
module aamc_verdict_checker import aamc_pkg::*; #(
    parameter int WINDOW = 8
) (
    input  logic   clk,
    input  logic   rst_n,
    aamc_sample_if sample,
    aamc_result_if result,
    aamc_cfg_if    cfg,
    output int     error_count,
    output int     open_verdicts
);

    localparam int DEPTH = WINDOW + 1;

    sample_t  hist_x [DEPTH];
    sample_t  hist_y [DEPTH];
    sample_t  hist_z [DEPTH];
    int       head;
    int       acc_x;
    int       acc_y;
    int       acc_z;
    count_t   n_checked;
    verdict_t run_code;
    logic     armed;
    skip_t    skip_left;
    thresh_t  lo_lim;
    thresh_t  hi_lim;
    skip_t    skip_reload;
    verdict_t verdicts_due [$];
    verdict_t want;
    int       errors = 0;

    function automatic thresh_t avg_square(int acc);
        int avg;
        avg = acc / WINDOW;
        if (avg < 0)
            avg = -avg;
        return thresh_t'(avg * avg);
    endfunction

    function automatic void clear_run();
        for (int i = 0; i < DEPTH; i++)
        begin
            hist_x[i] = '0;
            hist_y[i] = '0;
            hist_z[i] = '0;
        end
        head      = 0;
        acc_x     = 0;
        acc_y     = 0;
        acc_z     = 0;
        n_checked = '0;
        run_code  = VERDICT_OK;
        skip_left = skip_reload;
    endfunction

    function automatic void check_sample(sample_t x, sample_t y, sample_t z);
        int      nxt;
        thresh_t mag;
        nxt = (head + 1) % DEPTH;
        hist_x[head] = x;
        hist_y[head] = y;
        hist_z[head] = z;
        // The entry after the write slot is the one that drops out of the window.
        acc_x += int'(x) - int'(hist_x[nxt]);
        acc_y += int'(y) - int'(hist_y[nxt]);
        acc_z += int'(z) - int'(hist_z[nxt]);
        head = nxt;

        mag = avg_square(acc_x) + avg_square(acc_y) + avg_square(acc_z);
        if (n_checked > MAG_START && (mag < lo_lim || mag > hi_lim))
            run_code = VERDICT_MAG;
        if (x > XY_HI || x < XY_LO || y > XY_HI || y < XY_LO || z > Z_HI || z < Z_LO)
            run_code = VERDICT_SPIKE;

        if (n_checked > VERDICT_AT)
        begin
            verdicts_due.push_back(run_code);
            clear_run();
            armed = 1'b0;
        end
        else
        begin
            n_checked = n_checked + 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_lim      = MAG_LOW_RST;
            hi_lim      = MAG_HIGH_RST;
            skip_reload = SKIP_COUNT_RST;
            clear_run();
            skip_left   = '0;
            armed       = 1'b0;
            verdicts_due.delete();
            error_count   <= 0;
            open_verdicts <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("verdict: expected none, actual %0d", result.verdict);
                    errors++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (result.verdict !== want)
                    begin
                        $error("verdict: expected %0d, actual %0d", want, result.verdict);
                        errors++;
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MAG_LOW:    lo_lim = cfg.data;
                    CFG_MAG_HIGH:   hi_lim = cfg.data;
                    CFG_SKIP_COUNT: skip_reload = cfg.data[SKIP_W-1:0];
                    default:        ;
                endcase
            end

            if (sample.valid && sample.ready)
            begin
                if (sample.cmd == CMD_START)
                begin
                    clear_run();
                    armed = 1'b1;
                end
                else if (armed)
                begin
                    if (skip_left != 0)
                        skip_left = skip_left - 1'b1;
                    else
                        check_sample(sample.accel_x, sample.accel_y, sample.accel_z);
                end
            end

            error_count   <= errors;
            open_verdicts <= verdicts_due.size();
        end
    end

endmodule

// ===== tb/sv/accel_average_magnitude_check_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the accelerometer average magnitude check
// Drives a short directed sequence and then whole check runs under several
// threshold and skip settings, with random idling on both channels. A
// separate checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module accel_average_magnitude_check_unit_test import aamc_pkg::*; ();

    localparam int WINDOW     = 8;
    localparam int RUN_LEN    = 2002;
    localparam int DRAIN_WAIT = 8;
    // Watchdog limit for the whole test; keep a wide margin.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    typedef enum int {
        RUN_CLEAN,
        RUN_MAG,
        RUN_SPIKE,
        RUN_MAG_SPIKE,
        RUN_SPIKE_MAG,
        RUN_NOISE,
        RUN_RESTART
    } run_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int          error_count;
    int          open_verdicts;
    int unsigned cycle_count;
    bit          calm;
    bit          mid_cfg;
    int          gap_pct;
    int          z_center;
    int          amp;
    skip_t       skip_now;

    aamc_sample_if smp();
    aamc_result_if res();
    aamc_cfg_if    cfg_ch();

    accel_average_magnitude_check_unit #(.WINDOW(WINDOW)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    aamc_verdict_checker #(.WINDOW(WINDOW)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (smp),
        .result        (res),
        .cfg           (cfg_ch),
        .error_count   (error_count),
        .open_verdicts (open_verdicts)
    );

    always #2 clk = ~clk;

    task automatic send_item(logic cmd, sample_t x, sample_t y, sample_t z);
        if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        smp.valid   <= 1'b1;
        smp.cmd     <= cmd;
        smp.accel_x <= x;
        smp.accel_y <= y;
        smp.accel_z <= z;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (open_verdicts != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, thresh_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_SKIP_COUNT)
            skip_now = data[SKIP_W-1:0];
    endtask

    task automatic set_limits(thresh_t lo, thresh_t hi, skip_t skip, bit poke_unused);
        wait_idle();
        if (poke_unused)
            write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_MAG_LOW, lo);
        write_reg(CFG_MAG_HIGH, hi);
        write_reg(CFG_SKIP_COUNT, thresh_t'(skip));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic sample_t calm_axis(int center);
        return sample_t'(center + int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    function automatic sample_t spike_value(int limit);
        if ($urandom_range(0, 1))
            return sample_t'($urandom_range(limit + 1, 32767));
        return sample_t'(-int'($urandom_range(limit + 1, 32768)));
    endfunction

    function automatic sample_t rand_sample();
        return sample_t'($urandom);
    endfunction

    function automatic run_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return RUN_CLEAN;
        if (roll < 45)
            return RUN_MAG;
        if (roll < 60)
            return RUN_SPIKE;
        if (roll < 70)
            return RUN_MAG_SPIKE;
        if (roll < 80)
            return RUN_SPIKE_MAG;
        if (roll < 88)
            return RUN_NOISE;
        return RUN_RESTART;
    endfunction

    // One complete check run: a start, the skipped samples and enough checked
    // samples to close the run. A restart run is cut short by a second start.
    task automatic run_once(run_kind_t kind);
        int      starts;
        int      cut;
        int      mag_at;
        int      spike_at;
        bit      mag_on;
        bit      spike_on;
        sample_t sx;
        sample_t sy;
        sample_t sz;

        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 5;
            default: gap_pct = 25;
        endcase
        repeat ($urandom_range(0, 3))
            send_item(CMD_SAMPLE, rand_sample(), rand_sample(), rand_sample());

        starts = (kind == RUN_RESTART) ? 2 : 1;
        for (int s = 0; s < starts; s++)
        begin
            send_item(CMD_START, rand_sample(), rand_sample(), rand_sample());
            repeat (skip_now)
                send_item(CMD_SAMPLE, rand_sample(), rand_sample(), rand_sample());

            cut      = (s < starts - 1) ? $urandom_range(1, 1500) : RUN_LEN;
            mag_on   = (kind == RUN_MAG || kind == RUN_MAG_SPIKE || kind == RUN_SPIKE_MAG);
            spike_on = (kind == RUN_SPIKE || kind == RUN_MAG_SPIKE || kind == RUN_SPIKE_MAG ||
                        (kind == RUN_RESTART && s == 0));
            if (kind == RUN_MAG_SPIKE)
            begin
                mag_at   = $urandom_range(20, 900);
                spike_at = $urandom_range(1000, 1990);
            end
            else if (kind == RUN_SPIKE_MAG)
            begin
                spike_at = $urandom_range(20, 900);
                mag_at   = $urandom_range(1000, 1980);
            end
            else
            begin
                mag_at   = $urandom_range(20, 1980);
                spike_at = $urandom_range(0, cut - 1);
            end

            for (int k = 0; k < cut; k++)
            begin
                if (mid_cfg && s == starts - 1 && k == 1000)
                begin
                    // Move the thresholds while the run is still armed.
                    mag_at = $urandom_range(55000, 65000);
                    set_limits(thresh_t'(mag_at), thresh_t'(mag_at + $urandom_range(0, 12000)),
                               skip_t'($urandom_range(0, 15)), 1'b0);
                    mag_at = 0;
                end
                if (kind == RUN_NOISE)
                begin
                    sx = rand_sample();
                    sy = rand_sample();
                    sz = rand_sample();
                end
                else
                begin
                    sx = calm_axis(0);
                    sy = calm_axis(0);
                    sz = calm_axis(z_center);
                    if (mag_on && k >= mag_at && k < mag_at + 12)
                        sz = calm_axis(z_center / 3 + 64);
                    if (spike_on && k == spike_at)
                    begin
                        case ($urandom_range(0, 2))
                            0:       sx = spike_value(30);
                            1:       sy = spike_value(30);
                            default: sz = spike_value(300);
                        endcase
                    end
                end
                send_item(CMD_SAMPLE, sx, sy, sz);
            end
        end
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL accel_average_magnitude_check_unit");
        $finish;
    end

    // Verdict side: random stalls, none in the last part of the test.
    initial
    begin
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    initial
    begin
        smp.valid    <= 1'b0;
        smp.cmd      <= CMD_SAMPLE;
        smp.accel_x  <= '0;
        smp.accel_y  <= '0;
        smp.accel_z  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_MAG_LOW;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        calm     = 1'b0;
        mid_cfg  = 1'b0;
        gap_pct  = 10;
        z_center = 256;
        amp      = 10;
        skip_now = SKIP_COUNT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings: disarmed samples, a start
        // with junk axes, skipped and checked extremes, values at and just past
        // the spike limits, and a restart while armed.
        send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sd0);
        send_item(CMD_SAMPLE, -16'sd1, 16'sd1, 16'sh8000);
        send_item(CMD_START, 16'sh8000, 16'sh7FFF, -16'sd1);
        send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(CMD_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(CMD_SAMPLE, -16'sd1, -16'sd1, -16'sd1);
        send_item(CMD_SAMPLE, 16'sd31, -16'sd31, 16'sd301);
        send_item(CMD_SAMPLE, XY_HI, XY_LO, Z_HI);
        send_item(CMD_SAMPLE, XY_LO, XY_HI, Z_LO);
        send_item(CMD_SAMPLE, 16'sd31, 16'sd0, 16'sd0);
        send_item(CMD_SAMPLE, 16'sd0, -16'sd31, 16'sd0);
        send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd301);
        send_item(CMD_SAMPLE, 16'sd0, 16'sd0, -16'sd301);
        send_item(CMD_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
        repeat (4)
            send_item(CMD_SAMPLE, 16'sd1, 16'sd2, 16'sd3);
        send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
        send_item(CMD_SAMPLE, -16'sd31, 16'sd31, -16'sd301);

        repeat (5) run_once(pick_kind());

        // A realistic window around one g on z.
        set_limits(32'd60000, 32'd70000, 8'd0, 1'b0);
        repeat (8) run_once(pick_kind());

        // Window closed at zero: only a still sensor passes. Longest skip.
        z_center = 0;
        amp      = 0;
        set_limits(32'd0, 32'd0, 8'hFF, 1'b0);
        repeat (3) run_once(pick_kind());

        // Lowest bound at its maximum, so the magnitude check always trips.
        z_center = -256;
        amp      = 12;
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1);
        repeat (3) run_once(pick_kind());

        z_center = 256;
        set_limits($urandom, $urandom, skip_t'($urandom_range(0, 20)), 1'b1);
        repeat (3) run_once(pick_kind());

        mid_cfg = 1'b1;
        set_limits(32'd60000, 32'd70000, 8'd2, 1'b0);
        repeat (5) run_once(pick_kind());
        mid_cfg = 1'b0;

        set_limits(32'd50000, 32'd80000, 8'd3, 1'b0);
        calm = 1'b1;
        repeat (3) run_once(pick_kind());

        wait_idle();
        if (error_count == 0 && open_verdicts == 0)
            $display("PASS accel_average_magnitude_check_unit");
        else
            $display("FAIL accel_average_magnitude_check_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
design/aamc_pkg.sv
design/aamc_sample_if.sv
design/aamc_result_if.sv
design/aamc_cfg_if.sv
design/accel_average_magnitude_check_unit.sv
tb/sv/aamc_verdict_checker.sv
tb/sv/accel_average_magnitude_check_unit_test.sv
